### rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants and helpers for the environment sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned DivBits = 64;
  localparam int unsigned DenW    = 31;
  localparam int unsigned Latency = 83;

  localparam logic [2:0] RegTempCalib   = 3'd0;
  localparam logic [2:0] RegPressCalibA = 3'd1;
  localparam logic [2:0] RegPressCalibB = 3'd2;
  localparam logic [2:0] RegPressCalibC = 3'd3;
  localparam logic [2:0] RegHumidCalib  = 3'd4;

  localparam logic [28:0] HumMax = 29'd419430400;

  function automatic logic [63:0] sra64(logic [63:0] x, int unsigned s);
    sra64 = 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] x);
    sext16 = {{48{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sext12(logic [11:0] x);
    sext12 = {{52{x[11]}}, x};
  endfunction

endpackage

### rtl/env_sensor_compensation_top.sv
// Throughput: one transfer per cycle unless the master side stalls; the
// pipeline is set by the 64-stage divider.
// A stall on the master side holds the whole pipeline in place.
// Reset clears all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// Integer temperature, pressure and humidity compensation pipeline.
// ----------------------------------------------------------------------------
module env_sensor_compensation_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // raw_temperature, raw_pressure, raw_humidity
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fine_temperature, temperature, pressure, pressure_invalid, humidity, 2 pad
  output logic [127:0] m_axis_tdata
);

  localparam int unsigned Lat = esc_pkg::Latency;

  logic [47:0] tc_q;
  logic [63:0] pa_q, pb_q, hc_q;
  logic [15:0] pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
      hc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        esc_pkg::RegTempCalib:   tc_q <= cfg_wdata_i[47:0];
        esc_pkg::RegPressCalibA: pa_q <= cfg_wdata_i;
        esc_pkg::RegPressCalibB: pb_q <= cfg_wdata_i;
        esc_pkg::RegPressCalibC: pc_q <= cfg_wdata_i[15:0];
        esc_pkg::RegHumidCalib:  hc_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Lat:1] vld_q;

  assign en            = !vld_q[Lat] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-1:1], s_axis_tvalid};
    end
  end

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {48'b0, tc_q[15:0]};
  assign t2 = esc_pkg::sext16(tc_q[31:16]);
  assign t3 = esc_pkg::sext16(tc_q[47:32]);
  assign p1 = {48'b0, pa_q[15:0]};
  assign p2 = esc_pkg::sext16(pa_q[31:16]);
  assign p3 = esc_pkg::sext16(pa_q[47:32]);
  assign p4 = esc_pkg::sext16(pa_q[63:48]);
  assign p5 = esc_pkg::sext16(pb_q[15:0]);
  assign p6 = esc_pkg::sext16(pb_q[31:16]);
  assign p7 = esc_pkg::sext16(pb_q[47:32]);
  assign p8 = esc_pkg::sext16(pb_q[63:48]);
  assign p9 = esc_pkg::sext16(pc_q);
  assign h1 = {56'b0, hc_q[7:0]};
  assign h2 = esc_pkg::sext16(hc_q[23:8]);
  assign h3 = {56'b0, hc_q[31:24]};
  assign h4 = esc_pkg::sext12(hc_q[43:32]);
  assign h5 = esc_pkg::sext12(hc_q[55:44]);
  assign h6 = {{56{hc_q[63]}}, hc_q[63:56]};

  logic [19:0] rt, rp, rp9;
  logic [15:0] rh, rh5;
  assign rt = s_axis_tdata[19:0];
  assign rp = s_axis_tdata[39:20];
  assign rh = s_axis_tdata[55:40];

  // temperature
  logic [63:0] ta, tb, at2, bb2, at4, bt4, tf4, tf5, t5;
  logic [31:0] tf5w;
  assign ta = {47'b0, rt[19:3]} - {t1[62:0], 1'b0};
  assign tb = {48'b0, rt[19:4]} - t1;

  esc_mul u_at (.clk_i, .en_i(en), .a_i(ta), .b_i(t2), .p_o(at2));
  esc_mul u_bb (.clk_i, .en_i(en), .a_i(tb), .b_i(tb), .p_o(bb2));
  esc_dly #(.W(64), .D(2)) u_at_d (.clk_i, .en_i(en), .d_i(at2), .q_o(at4));
  esc_mul u_bt (.clk_i, .en_i(en), .a_i(esc_pkg::sra64(bb2, 12)), .b_i(t3), .p_o(bt4));

  assign tf4 = esc_pkg::sra64(at4, 11) + esc_pkg::sra64(bt4, 14);
  esc_dly #(.W(32), .D(1)) u_tf_d (.clk_i, .en_i(en), .d_i(tf4[31:0]), .q_o(tf5w));
  assign tf5 = {{32{tf5w[31]}}, tf5w};

  always_comb begin
    t5 = {tf5[61:0], 2'b0} + tf5 + 64'd128;
    if ($signed(t5) > 64'sd2147483647) begin
      t5 = 64'h0000_0000_7FFF_FFFF;
    end else if ($signed(t5) < -64'sd2147483648) begin
      t5 = 64'hFFFF_FFFF_8000_0000;
    end
  end

  // pressure
  logic [63:0] px, xx7, xp5_7, xp2_7, xxp6_9, xxp3_9, xp5_9, xp2_9;
  logic [63:0] y9, x1_9, x2_9, pr9, pn9, x11, num11;
  logic [63:0] q77, sq77, sq79, p9s79, p8q79, p8q81, q81, z1m81, ps81, ps82, pf82;
  logic [31:0] press82;
  logic        inv11, inv82;

  assign px = tf5 - 64'd128000;
  esc_mul u_xx  (.clk_i, .en_i(en), .a_i(px), .b_i(px), .p_o(xx7));
  esc_mul u_xp5 (.clk_i, .en_i(en), .a_i(px), .b_i(p5), .p_o(xp5_7));
  esc_mul u_xp2 (.clk_i, .en_i(en), .a_i(px), .b_i(p2), .p_o(xp2_7));
  esc_mul u_xxp6 (.clk_i, .en_i(en), .a_i(xx7), .b_i(p6), .p_o(xxp6_9));
  esc_mul u_xxp3 (.clk_i, .en_i(en), .a_i(xx7), .b_i(p3), .p_o(xxp3_9));
  esc_dly #(.W(64), .D(2)) u_xp5_d (.clk_i, .en_i(en), .d_i(xp5_7), .q_o(xp5_9));
  esc_dly #(.W(64), .D(2)) u_xp2_d (.clk_i, .en_i(en), .d_i(xp2_7), .q_o(xp2_9));
  esc_dly #(.W(20), .D(9)) u_rp_d (.clk_i, .en_i(en), .d_i(rp), .q_o(rp9));

  assign y9   = xxp6_9 + {xp5_9[46:0], 17'b0} + {p4[28:0], 35'b0};
  assign x1_9 = esc_pkg::sra64(xxp3_9, 8) + {xp2_9[51:0], 12'b0};
  assign x2_9 = 64'h0000_8000_0000_0000 + x1_9;
  assign pr9  = 64'd1048576 - {44'b0, rp9};
  assign pn9  = {pr9[32:0], 31'b0} - y9;

  esc_mul u_x2p1 (.clk_i, .en_i(en), .a_i(x2_9), .b_i(p1), .p_o(x11));
  esc_mul u_num  (.clk_i, .en_i(en), .a_i(pn9), .b_i(64'd3125), .p_o(num11));

  assign inv11 = x11[63:33] == '0;
  esc_div u_div (.clk_i, .en_i(en), .num_i(num11), .den_i(x11[63:33]), .quo_o(q77));

  assign sq77 = esc_pkg::sra64(q77, 13);
  esc_mul u_p9 (.clk_i, .en_i(en), .a_i(p9), .b_i(sq77), .p_o(p9s79));
  esc_mul u_p8 (.clk_i, .en_i(en), .a_i(p8), .b_i(q77), .p_o(p8q79));
  esc_dly #(.W(64), .D(2)) u_sq_d (.clk_i, .en_i(en), .d_i(sq77), .q_o(sq79));
  esc_dly #(.W(64), .D(4)) u_q_d (.clk_i, .en_i(en), .d_i(q77), .q_o(q81));
  esc_mul u_z1 (.clk_i, .en_i(en), .a_i(p9s79), .b_i(sq79), .p_o(z1m81));
  esc_dly #(.W(64), .D(2)) u_p8q_d (.clk_i, .en_i(en), .d_i(p8q79), .q_o(p8q81));

  assign ps81 = q81 + esc_pkg::sra64(z1m81, 25) + esc_pkg::sra64(p8q81, 19);
  esc_dly #(.W(64), .D(1)) u_ps_d (.clk_i, .en_i(en), .d_i(ps81), .q_o(ps82));
  esc_dly #(.W(1), .D(71)) u_inv_d (.clk_i, .en_i(en), .d_i(inv11), .q_o(inv82));

  assign pf82 = esc_pkg::sra64(ps82, 8) + {p7[59:0], 4'b0};

  always_comb begin
    if (inv82 || pf82[63]) begin
      press82 = '0;
    end else if (pf82[62:32] != '0) begin
      press82 = '1;
    end else begin
      press82 = pf82[31:0];
    end
  end

  // humidity
  logic [63:0] hv5, hx0, hx0_7, h5v7, vh6_7, vh3_7, hx7, hs7, hu7, su9, hx11;
  logic [63:0] hw9, wh11, hw11, xw13, ha13, aa15, hv17, ah17, hf17;
  logic [28:0] hum17, hum82;

  assign hv5 = tf5 - 64'd76800;
  esc_dly #(.W(16), .D(5)) u_rh_d (.clk_i, .en_i(en), .d_i(rh), .q_o(rh5));
  assign hx0 = {34'b0, rh5, 14'b0} - {h4[43:0], 20'b0};

  esc_dly #(.W(64), .D(2)) u_hx0_d (.clk_i, .en_i(en), .d_i(hx0), .q_o(hx0_7));
  esc_mul u_h5v (.clk_i, .en_i(en), .a_i(h5), .b_i(hv5), .p_o(h5v7));
  esc_mul u_vh6 (.clk_i, .en_i(en), .a_i(hv5), .b_i(h6), .p_o(vh6_7));
  esc_mul u_vh3 (.clk_i, .en_i(en), .a_i(hv5), .b_i(h3), .p_o(vh3_7));

  assign hx7 = esc_pkg::sra64(hx0_7 - h5v7 + 64'd16384, 15);
  assign hs7 = esc_pkg::sra64(vh6_7, 10);
  assign hu7 = esc_pkg::sra64(vh3_7, 11) + 64'd32768;
  esc_mul u_su (.clk_i, .en_i(en), .a_i(hs7), .b_i(hu7), .p_o(su9));
  esc_dly #(.W(64), .D(4)) u_hx_d (.clk_i, .en_i(en), .d_i(hx7), .q_o(hx11));

  assign hw9 = esc_pkg::sra64(su9, 10) + 64'd2097152;
  esc_mul u_wh2 (.clk_i, .en_i(en), .a_i(hw9), .b_i(h2), .p_o(wh11));
  assign hw11 = esc_pkg::sra64(wh11 + 64'd8192, 14);
  esc_mul u_xw (.clk_i, .en_i(en), .a_i(hx11), .b_i(hw11), .p_o(xw13));

  assign ha13 = esc_pkg::sra64(xw13, 15);
  esc_mul u_aa (.clk_i, .en_i(en), .a_i(ha13), .b_i(ha13), .p_o(aa15));
  esc_dly #(.W(64), .D(4)) u_hv_d (.clk_i, .en_i(en), .d_i(xw13), .q_o(hv17));
  esc_mul u_ah1 (.clk_i, .en_i(en), .a_i(esc_pkg::sra64(aa15, 7)), .b_i(h1), .p_o(ah17));

  assign hf17 = hv17 - esc_pkg::sra64(ah17, 4);

  always_comb begin
    if (hf17[63]) begin
      hum17 = '0;
    end else if (hf17 > {35'b0, esc_pkg::HumMax}) begin
      hum17 = esc_pkg::HumMax;
    end else begin
      hum17 = hf17[28:0];
    end
  end

  esc_dly #(.W(29), .D(65)) u_hum_d (.clk_i, .en_i(en), .d_i(hum17), .q_o(hum82));

  logic [63:0] tt82;
  esc_dly #(.W(64), .D(77)) u_tt_d (
    .clk_i, .en_i(en), .d_i({t5[31:0], tf5[31:0]}), .q_o(tt82)
  );

  logic [127:0] tdata_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {2'b0, hum82, inv82, press82, tt82};
    end
  end

  assign m_axis_tdata = tdata_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tdata[95:64] == 32'd0)
    else $error("pressure not zero with zero divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[125:97] <= esc_pkg::HumMax)
    else $error("humidity beyond clamp");

  a_temp_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[63:32] == 32'({m_axis_tdata[29:0], 2'b0} + m_axis_tdata[31:0] + 32'd128))
    else $error("temperature does not follow fine temperature");

  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[1])
    else $error("accepted transfer lost");

endmodule

### rtl/esc_dly.sv
// ----------------------------------------------------------------------------
// esc_dly
// Enabled delay line, D register stages of W bits.
// ----------------------------------------------------------------------------
module esc_dly #(
  parameter int unsigned W = esc_pkg::DataW,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int unsigned i = 1; i < D; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[D-1];

endmodule

### rtl/esc_mul.sv
// ----------------------------------------------------------------------------
// esc_mul
// Two-stage 64x64 multiplier, product modulo 2^64 from 32-bit partials.
// ----------------------------------------------------------------------------
module esc_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_d;
  logic [63:0] ll_q;
  logic [31:0] lh_q, hl_q;
  logic [63:0] p_q;

  assign ll_d = a_i[31:0] * b_i[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= 32'(a_i[31:0] * b_i[63:32]);
      hl_q <= 32'(a_i[63:32] * b_i[31:0]);
      p_q  <= ll_q + {lh_q + hl_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

### rtl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined signed divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module esc_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [63:0]               num_i,
  input  logic [esc_pkg::DenW-1:0]  den_i,
  output logic [63:0]               quo_o
);

  localparam int unsigned N  = esc_pkg::DivBits;
  localparam int unsigned DW = esc_pkg::DenW;

  logic [63:0]   n_q   [N+1];
  logic [DW:0]   rem_q [N+1];
  logic [DW-1:0] d_q   [N+1];
  logic          neg_q [N+1];
  logic [63:0]   quo_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= num_i[63] ? 64'(-num_i) : num_i;
      d_q[0]   <= den_i[DW-1] ? DW'(-den_i) : den_i;
      neg_q[0] <= num_i[63] ^ den_i[DW-1];
      rem_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_q[k][DW-1:0], n_q[k][63]};
    assign ge    = trial >= {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? trial - {1'b0, d_q[k]} : trial;
        n_q[k+1]   <= {n_q[k][62:0], ge};
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= neg_q[N] ? 64'(-n_q[N]) : n_q[N];
    end
  end

  assign quo_o = quo_q;

endmodule

### dv/env_sensor_compensation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation_checker
// Watches the calibration port and both streams, computes the expected
// compensated reading for every input transfer and compares field by field.
// ----------------------------------------------------------------------------
module env_sensor_compensation_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [63:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  output int           n_fail_o,
  output int           n_pending_o
);

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] temp;
    logic [31:0] press;
    logic        inval;
    logic [28:0] hum;
  } reading_t;

  logic [47:0] t_cal;
  logic [63:0] pa_cal, pb_cal, h_cal;
  logic [15:0] pc_cal;
  reading_t    readings_q[$];

  function automatic longint asr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint s16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6;
    longint a, b, tf, t, x, y, p, num, q, z1, z2, v, s, u, w;
    reading_t r;
    t1 = longint'(t_cal[15:0]);  t2 = s16(t_cal[31:16]); t3 = s16(t_cal[47:32]);
    p1 = longint'(pa_cal[15:0]); p2 = s16(pa_cal[31:16]);
    p3 = s16(pa_cal[47:32]);     p4 = s16(pa_cal[63:48]);
    p5 = s16(pb_cal[15:0]);      p6 = s16(pb_cal[31:16]);
    p7 = s16(pb_cal[47:32]);     p8 = s16(pb_cal[63:48]);
    p9 = s16(pc_cal);
    h1 = longint'(h_cal[7:0]);   h2 = s16(h_cal[23:8]);
    h3 = longint'(h_cal[31:24]);
    h4 = longint'($signed(h_cal[43:32])); h5 = longint'($signed(h_cal[55:44]));
    h6 = longint'($signed(h_cal[63:56]));
    a  = longint'(rt >> 3) - 2 * t1;
    b  = longint'(rt >> 4) - t1;
    tf = asr(a * t2, 11) + asr(asr(b * b, 12) * t3, 14);
    t  = tf * 5 + 128;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    r.fine  = tf[31:0];
    r.temp  = t[31:0];
    r.press = '0;
    r.inval = 1'b0;
    x = tf - 128000;
    y = x * x * p6 + ((x * p5) <<< 17) + (p4 <<< 35);
    x = asr(x * x * p3, 8) + ((x * p2) <<< 12);
    x = asr(((64'sd1 <<< 47) + x) * p1, 33);
    if (x == 0) begin
      r.inval = 1'b1;
    end else begin
      p   = 1048576 - longint'(rp);
      num = ((p <<< 31) - y) * 3125;
      q   = (x == -1) ? -num : num / x;
      z1  = asr(p9 * asr(q, 13) * asr(q, 13), 25);
      z2  = asr(p8 * q, 19);
      p   = asr(q + z1 + z2, 8) + (p7 <<< 4);
      if (p < 0) r.press = '0;
      else if (p > 64'sd4294967295) r.press = '1;
      else r.press = p[31:0];
    end
    v = tf - 76800;
    x = (longint'(rh) <<< 14) - (h4 <<< 20) - h5 * v;
    x = asr(x + 16384, 15);
    s = asr(v * h6, 10);
    u = asr(v * h3, 11) + 32768;
    w = asr(s * u, 10) + 2097152;
    w = asr(w * h2 + 8192, 14);
    v = x * w;
    a = asr(v, 15);
    v = v - asr(asr(a * a, 7) * h1, 4);
    if (v < 0) v = 0;
    if (v > 419430400) v = 419430400;
    r.hum = v[28:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t e, g;
    if (!rst_ni) begin
      t_cal <= '0; pa_cal <= '0; pb_cal <= '0; pc_cal <= '0; h_cal <= '0;
      n_fail_o = 0;
      n_pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          esc_pkg::RegTempCalib:   t_cal  <= cfg_wdata_i[47:0];
          esc_pkg::RegPressCalibA: pa_cal <= cfg_wdata_i;
          esc_pkg::RegPressCalibB: pb_cal <= cfg_wdata_i;
          esc_pkg::RegPressCalibC: pc_cal <= cfg_wdata_i[15:0];
          esc_pkg::RegHumidCalib:  h_cal  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        readings_q.push_back(compensate(s_axis_tdata[19:0], s_axis_tdata[39:20],
                                        s_axis_tdata[55:40]));
      if (m_axis_tvalid && m_axis_tready) begin
        g.fine  = m_axis_tdata[31:0];
        g.temp  = m_axis_tdata[63:32];
        g.press = m_axis_tdata[95:64];
        g.inval = m_axis_tdata[96];
        g.hum   = m_axis_tdata[125:97];
        if (readings_q.size() == 0) begin
          $display("%0t: unexpected transfer %h", $time, m_axis_tdata);
          n_fail_o++;
        end else begin
          e = readings_q.pop_front();
          if (e.fine != g.fine || e.temp != g.temp || e.press != g.press ||
              e.inval != g.inval || e.hum != g.hum) begin
            $display("%0t: expected fine %h temp %h press %h inv %b hum %h", $time,
                     e.fine, e.temp, e.press, e.inval, e.hum);
            $display("%0t: actual   fine %h temp %h press %h inv %b hum %h", $time,
                     g.fine, g.temp, g.press, g.inval, g.hum);
            n_fail_o++;
          end
        end
      end
      n_pending_o = readings_q.size();
    end
  end
endmodule

### dv/env_sensor_compensation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation_top_tb
// Drives raw readings under several calibration sets, realistic and extreme,
// with random gaps on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module env_sensor_compensation_top_tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_addr_i = '0;
  logic [63:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  int           n_fail, n_pending;
  bit           sink_on = 1'b0;

  // index outside the register list
  localparam logic [2:0] RegNone = 3'd7;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  env_sensor_compensation_top dut (.*);
  env_sensor_compensation_checker u_chk (.*, .n_fail_o(n_fail), .n_pending_o(n_pending));

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_addr_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (n_pending != 0) @(negedge clk_i);
    repeat (esc_pkg::Latency + 10) @(negedge clk_i);
  endtask

  // random gaps, phases of the pipeline hit at random
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rh, rp, rt};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                          logic [15:0] pc, logic [63:0] hc);
    cfg_write(esc_pkg::RegTempCalib, {16'h0, tc});
    cfg_write(esc_pkg::RegPressCalibA, pa);
    cfg_write(esc_pkg::RegPressCalibB, pb);
    cfg_write(esc_pkg::RegPressCalibC, {48'h0, pc});
    cfg_write(esc_pkg::RegHumidCalib, hc);
    cfg_write(RegNone, rnd64());
  endtask

  // realistic sensor trimming: T1 27504 T2 26435 T3 -1000, etc.
  localparam logic [47:0] TypT  = {16'hFC18, 16'h6743, 16'h6B70};
  localparam logic [63:0] TypPA = {16'h2710, 16'h0BD0, 16'hD4BC, 16'h8E3E};
  localparam logic [63:0] TypPB = {16'h3C6C, 16'h26AC, 16'hFFF9, 16'h008C};
  localparam logic [15:0] TypPC = 16'd6000;
  localparam logic [63:0] TypH  = {8'd30, 12'd50, 12'd339, 8'd0, 16'd360, 8'd75};

  always @(negedge clk_i) begin
    if (!sink_on) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(9) < 6) ? 1'b1 : ($urandom_range(40) == 0);
  end

  initial begin
    int k;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    drain();
    // all-zero calibration: divisor zero case
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    s_axis_tvalid <= 1'b0;
    drain();
    load_cal(TypT, TypPA, TypPB, TypPC, TypH);
    send_reading(20'd519888, 20'd415148, 16'd30000);
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    send_reading('0, '1, 16'h8000);
    send_reading('1, '0, 16'h0001);
    s_axis_tvalid <= 1'b0;
    drain();
    load_cal('1, '1, '1, '1, '1);
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    s_axis_tvalid <= 1'b0;
    drain();
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
             {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000,
             {8'h80, 12'h800, 12'h7FF, 8'hFF, 16'h8000, 8'hFF});
    send_reading('0, '0, '0);
    send_reading('1, '1, '1);
    send_reading(20'h80000, 20'h80000, 16'h8000);
    s_axis_tvalid <= 1'b0;
    drain();
    sink_on = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0)
        load_cal(48'(rnd64()), rnd64(), rnd64(), 16'(rnd64()), rnd64());
      else
        load_cal(TypT ^ 48'($urandom_range(255)), TypPA ^ 64'($urandom_range(255)),
                 TypPB ^ 64'($urandom_range(255)), TypPC ^ 16'($urandom_range(255)),
                 TypH ^ 64'($urandom_range(255)));
      for (k = 0; k < 100; k++) begin
        if (k == 50) begin
          s_axis_tvalid <= 1'b0;
          while (n_pending != 0) @(negedge clk_i);
        end
        send_reading(20'($urandom()), 20'($urandom()), 16'($urandom()));
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end
    if (n_fail == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
